// ----- src/vpbd_pkg.sv -----
// ----------------------------------------------------------------------------
// vpbd_pkg
// Shared types, constants and the range normalization helper for the VP9 boolean decoder.
// ----------------------------------------------------------------------------
package vpbd_pkg;

	localparam int BUDGET_W = 27;

	typedef enum logic [1:0] {
		FUNC_START  = 2'd0,
		FUNC_PUSH   = 2'd1,
		FUNC_DECODE = 2'd2,
		FUNC_FINISH = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_STARVED     = 3'd1,
		ST_ZERO_SIZE   = 3'd2,
		ST_PUSH_DROP   = 3'd3,
		ST_NOT_STARTED = 3'd4
	} status_t;

	typedef struct packed {
		func_t       func;
		logic [7:0]  data_byte;
		logic [7:0]  probability;
		logic [23:0] partition_bytes;
	} cmd_t;

	typedef struct packed {
		logic    result_bit;
		status_t status;
	} rsp_t;

	// Leading zeros of a nonzero range: number of doublings to reach 128.
	function automatic logic [2:0] norm_shifts(input logic [7:0] r);
		logic [2:0] n;
		n = 3'd7;
		if (r[7])      n = 3'd0;
		else if (r[6]) n = 3'd1;
		else if (r[5]) n = 3'd2;
		else if (r[4]) n = 3'd3;
		else if (r[3]) n = 3'd4;
		else if (r[2]) n = 3'd5;
		else if (r[1]) n = 3'd6;
		return n;
	endfunction

endpackage

// ----- src/vp9_bool_decoder.sv -----
// ----------------------------------------------------------------------------
// vp9_bool_decoder
// VP9 boolean entropy decoder with an MSB-first input bit buffer.
// ----------------------------------------------------------------------------
// Usage: commands arrive on cmd (cmd_valid/cmd_stall), results leave on rsp
// (rsp_valid/rsp_stall). A transfer happens when valid is high and stall low.
// Push appends a byte to the bit buffer and returns nothing unless the buffer
// lacks room (drop status). Start, decode and finish each return one result.
// Only one command is in flight: cmd_stall stays high until it is done.
// Steps per command, in order:
//   push    one buffer write per bit; early error results go straight out
//   starved at the compare step for decode, once the first 8 bits load for start
//   decode  multiply, compare, normalization shifts (0..7) one per cycle, commit
//   start   the first 8 bits load one per cycle, then a decode with shifts (0..1)
//   finish  remaining padding bits, checked one per cycle, then commit
// The rate is set by the single-bit buffer port and the shared shift step.
// The result sits in an output register; a new command is taken while it
// waits, and the next result holds inside the core until rsp is free.
// Reset clears the buffer fill, the coder (range 255, budget 0) and the
// started flag; buffer contents are not cleared and need no clearing pass.
module vp9_bool_decoder #(
	parameter int BUFFER_BITS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  vpbd_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output vpbd_pkg::rsp_t rsp
);

	localparam int AW = $clog2(BUFFER_BITS);
	localparam int CW = $clog2(BUFFER_BITS + 1);

	logic           busy, res_valid, res_ready;
	vpbd_pkg::rsp_t res;
	logic           wr_en, wr_bit, rd_bit;
	logic [AW-1:0]  wr_addr, rd_addr;
	logic           rsp_valid_q;
	vpbd_pkg::rsp_t rsp_q;

	vpbd_bit_ram #(
		.DEPTH (BUFFER_BITS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_bit  (wr_bit),
		.rd_addr (rd_addr),
		.rd_bit  (rd_bit)
	);

	vpbd_core #(
		.BUFFER_BITS (BUFFER_BITS),
		.AW          (AW),
		.CW          (CW)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_bit    (wr_bit),
		.rd_addr   (rd_addr),
		.rd_bit    (rd_bit)
	);

	assign cmd_stall = busy;
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= res;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- src/vpbd_bit_ram.sv -----
// ----------------------------------------------------------------------------
// vpbd_bit_ram
// Single-bit wide buffer memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module vpbd_bit_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_bit,
	input  logic [AW-1:0] rd_addr,
	output logic          rd_bit
);

	logic mem [DEPTH];
	logic rd_bit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_bit;
		end
		rd_bit_q <= mem[rd_addr];
	end

	assign rd_bit = rd_bit_q;

endmodule

// ----- src/vpbd_core.sv -----
// ----------------------------------------------------------------------------
// vpbd_core
// Sequencer, coder state and bit buffer pointers. One multiply, one
// compare/subtract and one single-bit shift are shared by start and decode.
// ----------------------------------------------------------------------------
module vpbd_core #(
	parameter int BUFFER_BITS = 64,
	parameter int AW          = 6,
	parameter int CW          = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  vpbd_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            res_valid,
	output vpbd_pkg::rsp_t  res,
	input  logic            res_ready,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output logic            wr_bit,
	output logic [AW-1:0]   rd_addr,
	input  logic            rd_bit
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WRITE,
		S_LOAD,
		S_MUL,
		S_CMP,
		S_NORM,
		S_COMMIT,
		S_DRAIN,
		S_RESP
	} state_t;

	state_t state_q;

	logic [AW-1:0] head_q, tail_q, rp_q, rp_next;
	logic [CW-1:0] count_q, used_q, avail;
	logic [7:0]    coder_value_q, coder_range_q;
	logic [vpbd_pkg::BUDGET_W-1:0] bit_budget_q, w_budget_q;
	logic          started_q;

	logic [7:0]    w_val_q, w_rng_q, prob_q, split_q, data_q;
	logic [2:0]    step_q;
	logic          flag_q, is_start_q;
	vpbd_pkg::rsp_t res_q;

	logic [15:0]   product;
	logic          take_one;
	logic [7:0]    new_rng;
	logic [2:0]    shifts, need;
	logic          starve, consume, budget_nz, push_full;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(BUFFER_BITS - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		product   = (w_rng_q - 8'd1) * prob_q;
		take_one  = (w_val_q >= split_q);
		new_rng   = take_one ? (w_rng_q - split_q) : split_q;
		shifts    = vpbd_pkg::norm_shifts(new_rng);
		need      = (w_budget_q < vpbd_pkg::BUDGET_W'(shifts)) ? w_budget_q[2:0] : shifts;
		avail     = count_q - used_q;
		budget_nz = (w_budget_q != '0);
		starve    = (state_q == S_CMP) && (avail < CW'(need));
		push_full = ({1'b0, count_q} + (CW + 1)'(8)) > (CW + 1)'(BUFFER_BITS);
		case (state_q)
			S_LOAD:  consume = 1'b1;
			S_NORM:  consume = budget_nz;
			S_DRAIN: consume = budget_nz && (avail != '0);
			default: consume = 1'b0;
		endcase
		rp_next = rp_q;
		if (starve) begin
			rp_next = head_q;
		end else if (consume) begin
			rp_next = ptr_inc(rp_q);
		end
	end

	// Read address is the next pointer value, so the registered rd_bit shows the bit at rp_q.
	assign rd_addr   = rp_next;
	assign wr_en     = (state_q == S_WRITE);
	assign wr_addr   = tail_q;
	assign wr_bit    = data_q[3'd7 - step_q];
	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_RESP) && res_ready;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			tail_q        <= '0;
			rp_q          <= '0;
			count_q       <= '0;
			used_q        <= '0;
			coder_value_q <= '0;
			coder_range_q <= 8'd255;
			bit_budget_q  <= '0;
			started_q     <= 1'b0;
			step_q        <= '0;
			flag_q        <= 1'b0;
			is_start_q    <= 1'b0;
		end else begin
			rp_q <= rp_next;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						used_q           <= '0;
						step_q           <= '0;
						data_q           <= cmd.data_byte;
						res_q.result_bit <= 1'b0;
						is_start_q       <= (cmd.func == vpbd_pkg::FUNC_START);
						case (cmd.func)
							vpbd_pkg::FUNC_PUSH: begin
								if (push_full) begin
									res_q.status <= vpbd_pkg::ST_PUSH_DROP;
									state_q      <= S_RESP;
								end else begin
									res_q.status <= vpbd_pkg::ST_OK;
									state_q      <= S_WRITE;
								end
							end
							vpbd_pkg::FUNC_START: begin
								if (cmd.partition_bytes == '0) begin
									res_q.status <= vpbd_pkg::ST_ZERO_SIZE;
									state_q      <= S_RESP;
								end else if (count_q < CW'(8)) begin
									res_q.status <= vpbd_pkg::ST_STARVED;
									state_q      <= S_RESP;
								end else begin
									res_q.status <= vpbd_pkg::ST_OK;
									w_val_q      <= '0;
									w_rng_q      <= 8'd255;
									prob_q       <= 8'd128;
									w_budget_q   <= {cmd.partition_bytes, 3'b000} -
										vpbd_pkg::BUDGET_W'(8);
									state_q      <= S_LOAD;
								end
							end
							vpbd_pkg::FUNC_DECODE: begin
								if (!started_q) begin
									res_q.status <= vpbd_pkg::ST_NOT_STARTED;
									state_q      <= S_RESP;
								end else begin
									res_q.status <= vpbd_pkg::ST_OK;
									w_val_q      <= coder_value_q;
									w_rng_q      <= coder_range_q;
									w_budget_q   <= bit_budget_q;
									prob_q       <= cmd.probability;
									state_q      <= S_MUL;
								end
							end
							vpbd_pkg::FUNC_FINISH: begin
								if (!started_q) begin
									res_q.status <= vpbd_pkg::ST_NOT_STARTED;
									state_q      <= S_RESP;
								end else begin
									res_q.status <= vpbd_pkg::ST_OK;
									w_budget_q   <= bit_budget_q;
									flag_q       <= 1'b1;
									state_q      <= S_DRAIN;
								end
							end
							default: begin
								res_q.status <= vpbd_pkg::ST_OK;
								state_q      <= S_IDLE;
							end
						endcase
					end
				end
				S_WRITE: begin
					tail_q <= ptr_inc(tail_q);
					step_q <= step_q + 1'b1;
					if (step_q == 3'd7) begin
						count_q <= count_q + CW'(8);
						state_q <= S_IDLE;
					end
				end
				S_LOAD: begin
					w_val_q <= {w_val_q[6:0], rd_bit};
					used_q  <= used_q + 1'b1;
					step_q  <= step_q + 1'b1;
					if (step_q == 3'd7) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					split_q <= product[15:8] + 8'd1;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (starve) begin
						res_q.status <= vpbd_pkg::ST_STARVED;
						state_q      <= S_RESP;
					end else begin
						if (take_one) begin
							w_val_q <= w_val_q - split_q;
						end
						w_rng_q          <= new_rng;
						res_q.result_bit <= take_one;
						step_q           <= shifts;
						state_q          <= (shifts == '0) ? S_COMMIT : S_NORM;
					end
				end
				S_NORM: begin
					w_rng_q <= {w_rng_q[6:0], 1'b0};
					w_val_q <= {w_val_q[6:0], budget_nz & rd_bit};
					if (budget_nz) begin
						w_budget_q <= w_budget_q - 1'b1;
						used_q     <= used_q + 1'b1;
					end
					step_q <= step_q - 1'b1;
					if (step_q == 3'd1) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					coder_value_q <= w_val_q;
					coder_range_q <= w_rng_q;
					bit_budget_q  <= w_budget_q;
					head_q        <= rp_q;
					count_q       <= count_q - used_q;
					if (is_start_q) begin
						started_q <= 1'b1;
					end
					state_q <= S_RESP;
				end
				S_DRAIN: begin
					if (consume) begin
						if (rd_bit) begin
							flag_q <= 1'b0;
						end
						w_budget_q <= w_budget_q - 1'b1;
						used_q     <= used_q + 1'b1;
					end else begin
						bit_budget_q     <= w_budget_q;
						head_q           <= rp_q;
						count_q          <= count_q - used_q;
						started_q        <= 1'b0;
						res_q.result_bit <= flag_q;
						state_q          <= S_RESP;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Fill level never passes the buffer size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(BUFFER_BITS))
		else $error("bit buffer count overflow");

	// Read pointer rests on the head between commands.
	a_rp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (rp_q == head_q))
		else $error("read pointer off head while idle");

	// A running coder always holds a normalized range.
	a_range_norm: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> coder_range_q[7])
		else $error("coder range not normalized");

	// Any failing result leaves the result bit clear.
	a_err_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_q.status != vpbd_pkg::ST_OK)) |-> !res_q.result_bit)
		else $error("result bit set on error status");

	// Between commands the tail sits count entries past the head.
	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		((CW + 1)'(head_q) + (CW + 1)'(count_q) == (CW + 1)'(tail_q) ||
		 (CW + 1)'(head_q) + (CW + 1)'(count_q) ==
		 (CW + 1)'(tail_q) + (CW + 1)'(BUFFER_BITS)))
		else $error("tail pointer out of step with head and count");

endmodule

// ----- tb/vp9_bool_decoder_checker.sv -----
// ----------------------------------------------------------------------------
// vp9_bool_decoder_checker
// Watches both channels of the boolean decoder. It mirrors the bit buffer and
// the coder state, and on every accepted command it works out the result the
// block owes. Each result transfer is compared field by field with the oldest
// owed result.
// ----------------------------------------------------------------------------
module vp9_bool_decoder_checker
	import vpbd_pkg::*;
#(
	parameter int BUFFER_BITS = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	input  logic  cmd_stall,
	input  cmd_t  cmd,
	input  logic  rsp_valid,
	input  logic  rsp_stall,
	input  rsp_t  rsp,
	output int    fail_count,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// mirrored decoder state
	bit                  fifo_bits[$];
	logic [7:0]          coder_val;
	logic [7:0]          coder_rng;
	logic [BUDGET_W-1:0] bits_left;
	bit                  running;

	rsp_t owed_q[$];
	int   bad_cnt;

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		bad_cnt++;
	endtask

	function automatic logic [7:0] split_of(input logic [7:0] rng, input logic [7:0] prob);
		return 8'(1 + (((int'(rng) - 1) * int'(prob)) >> 8));
	endfunction

	// buffer bits one decode would take: its shift count, capped by the budget
	function automatic int bits_wanted(input logic [7:0] val, input logic [7:0] rng,
			input logic [BUDGET_W-1:0] bud, input logic [7:0] prob);
		logic [7:0] split;
		logic [8:0] r;
		int         shifts;
		split = split_of(rng, prob);
		r = (val < split) ? split : rng - split;
		shifts = 0;
		while (r < 128) begin
			r = r << 1;
			shifts++;
		end
		return (shifts < bud) ? shifts : int'(bud);
	endfunction

	task automatic decode_bool(inout logic [7:0] val, inout logic [7:0] rng,
			inout logic [BUDGET_W-1:0] bud, input logic [7:0] prob, input int pos,
			output bit b, output int used);
		logic [7:0] split;
		bit         nb;
		split = split_of(rng, prob);
		if (val < split) begin
			rng = split;
			b = 1'b0;
		end else begin
			val = val - split;
			rng = rng - split;
			b = 1'b1;
		end
		used = 0;
		while (rng < 128) begin
			nb = 1'b0;
			// zeros are fed once the budget is spent
			if (bud != 0) begin
				nb = (pos < fifo_bits.size()) ? fifo_bits[pos] : 1'b0;
				pos++;
				bud--;
				used++;
			end
			rng = rng << 1;
			val = {val[6:0], nb};
		end
	endtask

	task automatic drop_bits(input int n);
		repeat (n) begin
			if (fifo_bits.size() != 0)
				void'(fifo_bits.pop_front());
		end
	endtask

	task automatic predict(input cmd_t c, output bit has, output rsp_t r);
		logic [7:0]          val;
		logic [7:0]          rng;
		logic [BUDGET_W-1:0] bud;
		bit                  b;
		int                  used;
		int                  n;
		has = 1'b1;
		r.result_bit = 1'b0;
		r.status = ST_OK;
		case (c.func)
			FUNC_PUSH: begin
				if (fifo_bits.size() + 8 > BUFFER_BITS) begin
					r.status = ST_PUSH_DROP;
				end else begin
					for (int i = 7; i >= 0; i--)
						fifo_bits.push_back(c.data_byte[i]);
					has = 1'b0;
				end
			end
			FUNC_START: begin
				if (c.partition_bytes == 0) begin
					r.status = ST_ZERO_SIZE;
				end else if (fifo_bits.size() < 8) begin
					r.status = ST_STARVED;
				end else begin
					val = '0;
					for (int i = 0; i < 8; i++)
						val = {val[6:0], fifo_bits[i]};
					rng = 8'd255;
					bud = BUDGET_W'(8 * int'(c.partition_bytes) - 8);
					// the marker bool may need one bit past the first byte
					if (fifo_bits.size() < 8 + bits_wanted(val, rng, bud, 8'd128)) begin
						r.status = ST_STARVED;
					end else begin
						decode_bool(val, rng, bud, 8'd128, 8, b, used);
						drop_bits(8 + used);
						coder_val = val;
						coder_rng = rng;
						bits_left = bud;
						running = 1'b1;
						r.result_bit = b;
					end
				end
			end
			FUNC_DECODE: begin
				if (!running) begin
					r.status = ST_NOT_STARTED;
				end else if (fifo_bits.size() <
						bits_wanted(coder_val, coder_rng, bits_left, c.probability)) begin
					r.status = ST_STARVED;
				end else begin
					decode_bool(coder_val, coder_rng, bits_left, c.probability, 0, b, used);
					drop_bits(used);
					r.result_bit = b;
				end
			end
			default: begin
				if (!running) begin
					r.status = ST_NOT_STARTED;
				end else begin
					// every buffered padding bit within the budget is checked, not only the last byte
					n = (bits_left < fifo_bits.size()) ? int'(bits_left) : fifo_bits.size();
					r.result_bit = 1'b1;
					for (int i = 0; i < n; i++)
						if (fifo_bits[i])
							r.result_bit = 1'b0;
					drop_bits(n);
					bits_left = bits_left - BUDGET_W'(n);
					running = 1'b0;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit   has;
		rsp_t want;
		rsp_t pred;
		if (!arst_n) begin
			fifo_bits.delete();
			owed_q.delete();
			coder_val = '0;
			coder_rng = 8'd255;
			bits_left = '0;
			running = 1'b0;
			bad_cnt = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			// predict first: a transfer on rsp this edge is always for an older command
			if (cmd_valid && !cmd_stall) begin
				predict(cmd, has, pred);
				if (has)
					owed_q.push_back(pred);
			end
			if (rsp_valid && !rsp_stall) begin
				if (owed_q.size() == 0) begin
					report($sformatf("result with nothing owed: bit %0b status %0d",
						rsp.result_bit, rsp.status));
				end else begin
					want = owed_q.pop_front();
					if (rsp.result_bit !== want.result_bit)
						report($sformatf("result_bit %0b, wanted %0b (status %0d)",
							rsp.result_bit, want.result_bit, want.status));
					if (rsp.status !== want.status)
						report($sformatf("status %0d, wanted %0d", rsp.status, want.status));
				end
			end
			pending <= owed_q.size();
			fail_count <= bad_cnt;
		end
	end

endmodule

// ----- tb/vp9_bool_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// vp9_bool_decoder_tb
// Drives the boolean decoder with a directed opening (errors, extremes, buffer
// overflow, padding checks) and then random partitions: pushed bytes, a start,
// a run of decodes with bytes trickled in, and mostly a finish, mixed with noise.
// Both channels idle at random; one long result hold-off backs the block up.
// ----------------------------------------------------------------------------
module vp9_bool_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vpbd_pkg::*;

	localparam int BUF_BITS     = 64;
	localparam int NUM_ITEMS    = 450;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   fail_count;
	int   pending;

	int items_sent;
	int burst_left;
	bit hold_go;
	bit hold_done;

	always #5 clk = ~clk;

	vp9_bool_decoder #(
		.BUFFER_BITS(BUF_BITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	vp9_bool_decoder_checker #(
		.BUFFER_BITS(BUF_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// unused fields carry random bits so every input bit toggles
	function automatic cmd_t mk(input func_t f, input logic [23:0] arg);
		cmd_t c;
		c.func = f;
		c.data_byte = 8'($urandom);
		c.probability = 8'($urandom);
		c.partition_bytes = 24'($urandom);
		case (f)
			FUNC_PUSH:   c.data_byte = arg[7:0];
			FUNC_START:  c.partition_bytes = arg;
			FUNC_DECODE: c.probability = arg[7:0];
			default: ;
		endcase
		return c;
	endfunction

	task automatic send(input cmd_t c);
		int gap;
		int r;
		gap = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 5)
				burst_left = $urandom_range(15, 40);
			else if (r < 40)
				gap = 0;
			else if (r < 85)
				gap = $urandom_range(1, 3);
			else if (r < 95)
				gap = $urandom_range(4, 10);
			else
				gap = $urandom_range(20, 40);
		end
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// one partition: preload, start, decodes with bytes trickled in, usually a finish
	task automatic send_partition();
		int  nbytes;
		int  pushed;
		int  preload;
		int  ndec;
		int  extra;
		bit  zero_tail;
		logic [7:0] prob;
		nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
		zero_tail = ($urandom_range(0, 3) == 0);
		pushed = 0;
		preload = $urandom_range(1, (nbytes < 4) ? nbytes : 4);
		repeat (preload) begin
			send(mk(FUNC_PUSH, (zero_tail && pushed >= nbytes - 2) ? 24'd0 : 24'($urandom)));
			pushed++;
		end
		send(mk(FUNC_START, 24'(nbytes)));
		ndec = $urandom_range(1, (3 * nbytes + 2 < 20) ? 3 * nbytes + 2 : 20);
		repeat (ndec) begin
			if (pushed < nbytes && $urandom_range(0, 2) == 0) begin
				send(mk(FUNC_PUSH, (zero_tail && pushed >= nbytes - 2) ? 24'd0 : 24'($urandom)));
				pushed++;
			end
			case ($urandom_range(0, 9))
				0:       prob = 8'd0;
				1:       prob = 8'd255;
				2:       prob = 8'd128;
				default: prob = 8'($urandom);
			endcase
			send(mk(FUNC_DECODE, 24'(prob)));
		end
		// now and then the partition is abandoned without a finish
		if ($urandom_range(0, 9) != 0) begin
			extra = 0;
			while (pushed < nbytes && extra < 6) begin
				send(mk(FUNC_PUSH, (zero_tail && pushed >= nbytes - 2) ? 24'd0 : 24'($urandom)));
				pushed++;
				extra++;
			end
			send(mk(FUNC_FINISH, 24'd0));
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		items_sent = 0;
		burst_left = 0;
		hold_go = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// errors before any partition is open
		send(mk(FUNC_DECODE, 24'd128));
		send(mk(FUNC_FINISH, 24'd0));
		send(mk(FUNC_START, 24'd0));
		send(mk(FUNC_START, 24'd1));
		// first byte 0xFF needs one more bit for the marker: starved, then fine
		send(mk(FUNC_PUSH, 24'hFF));
		send(mk(FUNC_START, 24'hFFFFFF));
		send(mk(FUNC_PUSH, 24'h00));
		send(mk(FUNC_START, 24'hFFFFFF));
		send(mk(FUNC_DECODE, 24'd0));
		send(mk(FUNC_DECODE, 24'd255));
		// fill the buffer past its end, the last push must drop
		send(mk(FUNC_PUSH, 24'hA5));
		send(mk(FUNC_PUSH, 24'h5A));
		send(mk(FUNC_PUSH, 24'hFF));
		send(mk(FUNC_PUSH, 24'h00));
		send(mk(FUNC_PUSH, 24'hA5));
		send(mk(FUNC_PUSH, 24'h5A));
		send(mk(FUNC_PUSH, 24'hFF));
		send(mk(FUNC_PUSH, 24'h00));
		send(mk(FUNC_PUSH, 24'hC3));
		// huge budget: finish checks every buffered bit
		send(mk(FUNC_FINISH, 24'd0));
		// one-byte partition: decodes run on fed zeros, empty padding passes
		send(mk(FUNC_PUSH, 24'h00));
		send(mk(FUNC_START, 24'd1));
		send(mk(FUNC_DECODE, 24'd255));
		send(mk(FUNC_DECODE, 24'd1));
		send(mk(FUNC_FINISH, 24'd0));

		while (items_sent < NUM_ITEMS) begin
			if (items_sent >= HOLD_AT)
				hold_go = 1'b1;
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 4))
					send(mk(func_t'($urandom_range(0, 3)),
						$urandom_range(0, 1) ? 24'($urandom_range(0, 8)) : 24'($urandom)));
			end else begin
				send_partition();
			end
		end
		cmd_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : rsp_side
		int r;
		hold_done = 1'b0;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_go && !hold_done) begin
				// long hold-off while commands keep coming: the block must back up
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (r < 15) begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end else if (r < 20) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(15, 40)) @(posedge clk);
			end else begin
				rsp_stall <= r[0];
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
